// ===== src/periodic_oneshot_compare_timer_macros.svh =====
// Assertion macros shared by the timer RTL.
// POCT_ASSERT_IMPL checks cons in the same cycle as ante.
// POCT_ASSERT_NEXT checks cons in the cycle after ante.
`ifndef PERIODIC_ONESHOT_COMPARE_TIMER_MACROS_SVH
`define PERIODIC_ONESHOT_COMPARE_TIMER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define POCT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("periodic_oneshot_compare_timer: same-cycle check failed");
`define POCT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("periodic_oneshot_compare_timer: next-cycle check failed");
`else
`define POCT_ASSERT_IMPL(label, ante, cons)
`define POCT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/poct_pkg.sv =====
`default_nettype none

package poct_pkg;

   localparam int unsigned TIME_W     = 64;
   localparam int unsigned FREQ_W     = 32;
   localparam int unsigned DIV_STEPS  = FREQ_W;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd62500000;

   // register index taken from the word address bit
   localparam logic CSR_IDX_FREQ = 1'b0;

   typedef enum logic [1:0] {
      OP_TICK         = 2'd0,
      OP_ARM_PERIODIC = 2'd1,
      OP_ARM_ONESHOT  = 2'd2,
      OP_SERVICE      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_OFF      = 2'd0,
      MODE_PERIODIC = 2'd1,
      MODE_ONESHOT  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIVIDE,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic capture;
      logic div_start;
      logic update;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   div_done;
      logic   rsp_full;
   } status_type;

endpackage

`default_nettype wire

// ===== src/poct_div.sv =====
`default_nettype none

`include "periodic_oneshot_compare_timer_macros.svh"

module poct_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [poct_pkg::FREQ_W-1:0]  dividend,
   input  wire logic [poct_pkg::FREQ_W-1:0]  divisor,
   output logic                              done,
   output logic [poct_pkg::FREQ_W-1:0]       quotient
);
   import poct_pkg::*;

   logic [FREQ_W-1:0]    rem_ff, rem_in;
   logic [FREQ_W-1:0]    quo_ff, quo_in;
   logic [FREQ_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [FREQ_W:0]      shifted;
   logic [FREQ_W:0]      diff;

   // one restoring step: shift in the next dividend bit, try the subtract
   assign shifted = {rem_ff, quo_ff[FREQ_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[FREQ_W]) begin
            rem_in = diff[FREQ_W-1:0];
            quo_in = {quo_ff[FREQ_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[FREQ_W-1:0];
            quo_in = {quo_ff[FREQ_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== src/poct_dp.sv =====
`default_nettype none

`include "periodic_oneshot_compare_timer_macros.svh"

module poct_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire poct_pkg::cmd_type                cmd,
   output poct_pkg::status_type                  status,
   input  wire logic [1:0]                       req_opcode,
   input  wire logic [poct_pkg::TIME_W-1:0]      req_now,
   input  wire logic [poct_pkg::FREQ_W-1:0]      req_rate_hz,
   input  wire logic [poct_pkg::TIME_W-1:0]      req_deadline,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_valid,
   output logic                                  rsp_fire,
   output logic [poct_pkg::TIME_W-1:0]           rsp_event_count,
   output logic                                  rsp_enabled,
   output logic [1:0]                            rsp_mode,
   output logic [poct_pkg::TIME_W-1:0]           rsp_compare_value,
   input  wire logic                             csr_wr,
   input  wire logic [poct_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [poct_pkg::FREQ_W-1:0]      csr_pwdata,
   output logic [poct_pkg::FREQ_W-1:0]           csr_prdata
);
   import poct_pkg::*;

   // captured input word
   op_type            op_ff, op_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [FREQ_W-1:0] rate_ff, rate_in;
   logic [TIME_W-1:0] dl_ff, dl_in;

   // timer state
   logic [FREQ_W-1:0] freq_ff, freq_in;
   mode_type          mode_ff, mode_in;
   logic              enable_ff, enable_in;
   logic [FREQ_W-1:0] period_ff, period_in;
   logic [TIME_W-1:0] deadline_ff, deadline_in;
   logic [TIME_W-1:0] event_ff, event_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_fire_ff;
   logic [TIME_W-1:0] rsp_event_ff;
   logic              rsp_enabled_ff;
   mode_type          rsp_mode_ff;
   logic [TIME_W-1:0] rsp_compare_ff;

   logic              div_done;
   logic [FREQ_W-1:0] quotient;
   logic [FREQ_W-1:0] new_period;
   logic [TIME_W-1:0] arm_sum;
   logic [TIME_W-1:0] late_sum;
   logic [TIME_W-1:0] early_sum;
   logic              late;
   logic              fire;

   poct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (freq_ff),
      .divisor  (rate_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // hold the input word for the whole operation
   always_comb begin
      op_in   = op_ff;
      now_in  = now_ff;
      rate_in = rate_ff;
      dl_in   = dl_ff;
      if (cmd.capture) begin
         op_in   = op_type'(req_opcode);
         now_in  = req_now;
         rate_in = req_rate_hz;
         dl_in   = req_deadline;
      end
   end

   // configuration write
   always_comb begin
      freq_in = freq_ff;
      if (csr_wr && (csr_paddr[2] == CSR_IDX_FREQ)) begin
         freq_in = csr_pwdata;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_FREQ) ? freq_ff : '0;

   // a zero rate gives a zero period, as does rate above frequency
   assign new_period = (rate_ff == '0) ? '0 : quotient;
   assign arm_sum    = now_ff + {{(TIME_W-FREQ_W){1'b0}}, new_period};
   assign late_sum   = now_ff + {{(TIME_W-FREQ_W){1'b0}}, period_ff};
   assign early_sum  = deadline_ff + {{(TIME_W-FREQ_W){1'b0}}, period_ff};
   assign late       = (now_ff >= deadline_ff);

   // apply the operation to the timer state
   always_comb begin
      mode_in     = mode_ff;
      enable_in   = enable_ff;
      period_in   = period_ff;
      deadline_in = deadline_ff;
      event_in    = event_ff;
      if (cmd.update) begin
         case (op_ff)
            OP_ARM_PERIODIC: begin
               if (new_period == '0) begin
                  mode_in   = MODE_OFF;
                  enable_in = 1'b0;
               end else begin
                  period_in   = new_period;
                  mode_in     = MODE_PERIODIC;
                  deadline_in = arm_sum;
                  enable_in   = 1'b1;
               end
            end
            OP_ARM_ONESHOT: begin
               mode_in     = MODE_ONESHOT;
               deadline_in = dl_ff;
               enable_in   = 1'b1;
            end
            OP_SERVICE: begin
               event_in = event_ff + 1'b1;
               if (mode_ff == MODE_PERIODIC) begin
                  deadline_in = late ? late_sum : early_sum;
               end else begin
                  mode_in   = MODE_OFF;
                  enable_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // compare against the updated deadline
   assign fire = enable_ff && (now_ff >= deadline_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      now_ff  <= now_in;
      rate_ff <= rate_in;
      dl_ff   <= dl_in;
      if (cmd.load_rsp) begin
         rsp_fire_ff    <= fire;
         rsp_event_ff   <= event_ff;
         rsp_enabled_ff <= enable_ff;
         rsp_mode_ff    <= mode_ff;
         rsp_compare_ff <= deadline_ff;
      end
      if (reset) begin
         freq_ff      <= FREQ_RESET;
         mode_ff      <= MODE_OFF;
         enable_ff    <= 1'b0;
         period_ff    <= '0;
         deadline_ff  <= '0;
         event_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         freq_ff      <= freq_in;
         mode_ff      <= mode_in;
         enable_ff    <= enable_in;
         period_ff    <= period_in;
         deadline_ff  <= deadline_in;
         event_ff     <= event_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.op       = op_ff;
   assign status.div_done = div_done;
   assign status.rsp_full = rsp_valid_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fire          = rsp_fire_ff;
   assign rsp_event_count   = rsp_event_ff;
   assign rsp_enabled       = rsp_enabled_ff;
   assign rsp_mode          = rsp_mode_ff;
   assign rsp_compare_value = rsp_compare_ff;

   // compare enable and a live mode go together
   `POCT_ASSERT_IMPL(a_enable_has_mode, enable_ff, mode_ff != MODE_OFF)
   // periodic mode always runs with a nonzero period
   `POCT_ASSERT_IMPL(a_periodic_period, mode_ff == MODE_PERIODIC, period_ff != '0)
   // only a service step moves the event count
   `POCT_ASSERT_NEXT(a_count_on_service, !(cmd.update && (op_ff == OP_SERVICE)),
                     $stable(event_ff))

endmodule

`default_nettype wire

// ===== src/poct_ctrl.sv =====
`default_nettype none

`include "periodic_oneshot_compare_timer_macros.svh"

module poct_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  rsp_ready,
   input  wire poct_pkg::status_type  status,
   output poct_pkg::cmd_type          cmd
);
   import poct_pkg::*;

   state_type state_ff, state_in;
   logic      ready;

   // in idle, take a word once the result register is empty or being drained
   assign ready = (state_ff == ST_IDLE) && (!status.rsp_full || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = (status.op == OP_ARM_PERIODIC) ? ST_DIVIDE : ST_UPDATE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid && ready;
         end
         ST_DECODE: begin
            cmd.div_start = (status.op == OP_ARM_PERIODIC);
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_RESULT: begin
            cmd.load_rsp = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = ready;

   // the result register is never overwritten while full
   `POCT_ASSERT_IMPL(a_load_when_empty, state_ff == ST_RESULT, !status.rsp_full)
   // the divider only runs for a periodic arm
   `POCT_ASSERT_IMPL(a_divide_periodic, state_ff == ST_DIVIDE, status.op == OP_ARM_PERIODIC)

endmodule

`default_nettype wire

// ===== src/periodic_oneshot_compare_timer.sv =====
// Channel  | Direction | Handshake         | Payload
// req      | in        | req_valid/ready   | opcode, now, rate_hz, deadline
// rsp      | out       | rsp_valid/ready   | fire, event_count, enabled, mode,
//          |           |                   | compare_value
// csr      | in/out    | APB psel/penable  | counter_frequency at byte 0
//
// Tick, arm one-shot and service go from accept through decode, update and result back to idle.
// Arm periodic adds a divide state before update, where the 32-step restoring divider runs.
// Reset is synchronous: state clears, counter_frequency returns to 62500000.
// A result waiting in the output register holds off the next word until it is
// taken; the block accepts that word in the cycle the result is taken.
`default_nettype none

module periodic_oneshot_compare_timer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_opcode,
   input  wire logic [poct_pkg::TIME_W-1:0]      req_now,
   input  wire logic [poct_pkg::FREQ_W-1:0]      req_rate_hz,
   input  wire logic [poct_pkg::TIME_W-1:0]      req_deadline,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_fire,
   output logic [poct_pkg::TIME_W-1:0]           rsp_event_count,
   output logic                                  rsp_enabled,
   output logic [1:0]                            rsp_mode,
   output logic [poct_pkg::TIME_W-1:0]           rsp_compare_value,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [poct_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [poct_pkg::FREQ_W-1:0]      csr_pwdata,
   output logic [poct_pkg::FREQ_W-1:0]           csr_prdata,
   output logic                                  csr_pready
);
   import poct_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_wr;

   // zero-wait APB: write on the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   poct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   poct_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_now           (req_now),
      .req_rate_hz       (req_rate_hz),
      .req_deadline      (req_deadline),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_fire          (rsp_fire),
      .rsp_event_count   (rsp_event_count),
      .rsp_enabled       (rsp_enabled),
      .rsp_mode          (rsp_mode),
      .rsp_compare_value (rsp_compare_value),
      .csr_wr            (csr_wr),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata)
   );

endmodule

`default_nettype wire
